// File: hdl/lpwt_pkg.sv
// ----------------------------------------------------------------------------
// lpwt_pkg
// Shared constants, codes and controller/datapath interface types for the
// linear probing word table.
// ----------------------------------------------------------------------------
package lpwt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = SLOT_W + 1;
  localparam int KEY_BYTES   = 8;
  localparam int KEY_W       = 8 * KEY_BYTES;
  localparam int LEN_W       = 4;
  localparam int CHAR_W      = 7;
  localparam int IDX_W       = $clog2(KEY_BYTES) > 0 ? $clog2(KEY_BYTES) : 1;
  localparam int HASH_MULT   = 123;
  // h * 123 + c stays below 2^15 for an 8-bit h
  localparam int REM_W       = 15;
  // quotient of one reduction stays below 256, so 8 subtract steps
  localparam int DIV_STEPS   = 8;
  localparam int STEP_W      = $clog2(DIV_STEPS);
  localparam int DVS_W       = SIZE_W + DIV_STEPS - 1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    mul;
    logic    div_step;
    logic    probe_init;
    logic    rd;
    logic    insert;
    logic    advance;
    logic    finish;
    status_t finish_code;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic hash_done;
    logic div_last;
    logic probe_full;
    logic slot_valid;
    logic key_match;
  } stat_t;

endpackage

// File: hdl/linear_probe_word_table.sv
// ----------------------------------------------------------------------------
// linear_probe_word_table
// Open-addressing word table with linear probing. Each word is hashed by
// h = (h * 123 + c) mod size and then inserted, found, or reported full.
//
// Usage:
//   Input: drive in_word_key / in_word_len and pulse start while busy is
//   low; the beat is taken on that edge. busy stays high until done.
//   Output: out_valid is high for one cycle with out_status, out_slot and
//   out_home_slot; the receiver cannot stall it.
//   Config: cfg_we with cfg_wdata sets the slot count; write only while idle.
//   Sequence: load, then per character one multiply-add plus eight
//   shift-subtract steps of the reduction, then per probed slot a memory
//   read and a compare, then the result beat. A full table probes every
//   slot in use and ends with one more check that reports it full.
//   One word at a time; a new start is taken in the cycle the result is
//   shown.
//   Reset: all slots marked empty at once, slot count returns to 256.
// ----------------------------------------------------------------------------
module linear_probe_word_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [lpwt_pkg::KEY_W-1:0]  in_word_key,
  input  logic [lpwt_pkg::LEN_W-1:0]  in_word_len,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [lpwt_pkg::SLOT_W-1:0] out_slot,
  output logic [lpwt_pkg::SLOT_W-1:0] out_home_slot,
  input  logic                        cfg_we,
  input  logic [lpwt_pkg::SIZE_W-1:0] cfg_wdata
);
  import lpwt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  lpwt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath
  lpwt_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_word_key   (in_word_key),
    .in_word_len   (in_word_len),
    .cmd           (cmd),
    .stat          (stat),
    .out_status    (out_status),
    .out_slot      (out_slot),
    .out_home_slot (out_home_slot)
  );

endmodule

// File: hdl/lpwt_ctrl.sv
// ----------------------------------------------------------------------------
// lpwt_ctrl
// Sequencer for hashing and probing: steps the datapath through the hash
// reduction, the probe walk and the result beat.
// ----------------------------------------------------------------------------
module lpwt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output logic           out_valid,
  output lpwt_pkg::cmd_t cmd,
  input  lpwt_pkg::stat_t stat
);
  import lpwt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_DIV,
    S_PRD,
    S_PCMP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    cmd.finish_code = ST_FULL;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (stat.hash_done) begin
          cmd.probe_init = 1'b1;
          state_nxt      = S_PRD;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_HASH;
      end
      S_PRD: begin
        if (stat.probe_full) begin
          cmd.finish      = 1'b1;
          cmd.finish_code = ST_FULL;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_PCMP;
        end
      end
      S_PCMP: begin
        if (!stat.slot_valid) begin
          cmd.insert      = 1'b1;
          cmd.finish      = 1'b1;
          cmd.finish_code = ST_INSERTED;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end else if (stat.key_match) begin
          cmd.finish      = 1'b1;
          cmd.finish_code = ST_PRESENT;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_PRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: hdl/lpwt_dpath.sv
// ----------------------------------------------------------------------------
// lpwt_dpath
// Datapath: size register, key latch, hash reduction by shift-subtract,
// slot memory with valid bits, probe pointer and result registers.
// ----------------------------------------------------------------------------
module lpwt_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lpwt_pkg::SIZE_W-1:0] cfg_wdata,
  input  logic [lpwt_pkg::KEY_W-1:0]  in_word_key,
  input  logic [lpwt_pkg::LEN_W-1:0]  in_word_len,
  input  lpwt_pkg::cmd_t              cmd,
  output lpwt_pkg::stat_t             stat,
  output logic [1:0]                  out_status,
  output logic [lpwt_pkg::SLOT_W-1:0] out_slot,
  output logic [lpwt_pkg::SLOT_W-1:0] out_home_slot
);
  import lpwt_pkg::*;

  logic [SIZE_W-1:0] slot_cnt_cfg_r;
  logic [SIZE_W-1:0] size_r;
  logic [KEY_W-1:0]  key_r;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  chr_idx_r;
  logic [SLOT_W-1:0] h_r;
  logic [REM_W-1:0]  rem_r;
  logic [STEP_W-1:0] step_r;
  logic [SLOT_W-1:0] pos_r;
  logic [SIZE_W-1:0] count_r;
  logic              rdv_r;
  logic [KEY_W-1:0]  rd_key_r;
  logic [LEN_W-1:0]  rd_len_r;
  logic [1:0]        out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [SLOT_W-1:0] out_home_r;

  logic [TABLE_DEPTH-1:0]      valid_r;
  logic [KEY_W+LEN_W-1:0]      mem [TABLE_DEPTH];

  logic [SIZE_W-1:0] size_act;
  logic [LEN_W-1:0]  len_sat;
  logic [KEY_W-1:0]  key_norm;
  logic [CHAR_W-1:0] cur_chr;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W-1:0]  rem_ext;
  logic [REM_W-1:0]  rem_step;
  logic [SIZE_W-1:0] pos_inc;

  // active size and saturated length
  always_comb begin
    size_act = slot_cnt_cfg_r;
    if (slot_cnt_cfg_r == '0) size_act = SIZE_W'(1);
    if (slot_cnt_cfg_r > SIZE_W'(TABLE_DEPTH)) size_act = SIZE_W'(TABLE_DEPTH);
    len_sat = (in_word_len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : in_word_len;
  end

  // key normalized to 7-bit characters, zero beyond the length
  always_comb begin
    for (int i = 0; i < KEY_BYTES; i++) begin
      key_norm[i*8 +: 8] = (LEN_W'(i) < len_sat) ?
                           {1'b0, in_word_key[i*8 +: CHAR_W]} : 8'd0;
    end
  end

  assign cur_chr = key_r[chr_idx_r[IDX_W-1:0]*8 +: CHAR_W];

  // one restoring subtract step of the reduction
  always_comb begin
    dvs      = DVS_W'(size_r) << step_r;
    rem_ext  = DVS_W'(rem_r);
    rem_step = (rem_ext >= dvs) ? REM_W'(rem_ext - dvs) : rem_r;
  end

  assign pos_inc = SIZE_W'(pos_r) + SIZE_W'(1);

  assign stat.hash_done  = (chr_idx_r == len_r);
  assign stat.div_last   = (step_r == '0);
  assign stat.probe_full = (count_r == size_r);
  assign stat.slot_valid = rdv_r;
  assign stat.key_match  = (rd_len_r == len_r) && (rd_key_r == key_r);

  // size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_cnt_cfg_r <= SIZE_W'(TABLE_DEPTH);
    end else if (cfg_we) begin
      slot_cnt_cfg_r <= cfg_wdata;
    end
  end

  // valid marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.insert) begin
      valid_r[pos_r] <= 1'b1;
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.insert) mem[pos_r] <= {len_r, key_r};
    if (cmd.rd) begin
      {rd_len_r, rd_key_r} <= mem[pos_r];
      rdv_r                <= valid_r[pos_r];
    end
  end

  // hash and probe registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r     <= key_norm;
      len_r     <= len_sat;
      size_r    <= size_act;
      chr_idx_r <= '0;
      h_r       <= '0;
    end
    if (cmd.mul) begin
      rem_r  <= REM_W'(h_r * HASH_MULT) + REM_W'(cur_chr);
      step_r <= STEP_W'(DIV_STEPS - 1);
    end
    if (cmd.div_step) begin
      rem_r  <= rem_step;
      step_r <= step_r - STEP_W'(1);
      if (step_r == '0) begin
        h_r       <= rem_step[SLOT_W-1:0];
        chr_idx_r <= chr_idx_r + LEN_W'(1);
      end
    end
    if (cmd.probe_init) begin
      pos_r   <= h_r;
      count_r <= '0;
    end
    if (cmd.advance) begin
      pos_r   <= (pos_inc >= size_r) ? '0 : pos_inc[SLOT_W-1:0];
      count_r <= count_r + SIZE_W'(1);
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= cmd.finish_code;
      out_slot_r   <= (cmd.finish_code == ST_FULL) ? '0 : pos_r;
      out_home_r   <= h_r;
    end
  end

  assign out_status    = out_status_r;
  assign out_slot      = out_slot_r;
  assign out_home_slot = out_home_r;

endmodule
